@@ hdl/ffba_pkg.sv @@
package ffba_pkg;

    localparam int DATA_W  = 32;
    localparam int PAGES_W = 21;
    localparam int STAT_W  = 2;

    // configuration register indexes
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_PAGES = 1'b1;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] alloc_size;
        logic [DATA_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_addr;
        logic [STAT_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic [DATA_W-1:0]  heap_base;
        logic [PAGES_W-1:0] heap_pages;
    } cfg_t;

    // one table entry as kept in memory
    typedef struct packed {
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] offset;
        logic              in_use;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESP
    } state_t;

endpackage

@@ hdl/ffba_ram.sv @@
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/ffba_core.sv @@
module ffba_core #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ffba_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  ffba_pkg::req_t in_data,
    output logic          res_valid,
    input  logic          res_ready,
    output ffba_pkg::rsp_t res_data
);

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_W  = ffba_pkg::PAGES_W + $clog2(PAGE_BYTES + 1);
    localparam int NEED_W = ffba_pkg::DATA_W + 2;
    localparam int CMP_W  = (LIM_W > NEED_W) ? LIM_W : NEED_W;
    localparam int ENT_W  = $bits(ffba_pkg::entry_t);

    ffba_pkg::state_t state_reg, state_next;
    ffba_pkg::req_t   req_reg, req_next;
    ffba_pkg::rsp_t   res_reg, res_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ffba_pkg::DATA_W-1:0] used_reg, used_next;
    logic [LIM_W-1:0] limit_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    ffba_pkg::entry_t ram_wdata;
    ffba_pkg::entry_t ram_rdata;
    logic [ENT_W-1:0] ram_rdata_raw;

    logic                        hit;
    logic                        last;
    logic [ffba_pkg::DATA_W-1:0] entry_addr;
    logic [ffba_pkg::DATA_W-1:0] new_addr;
    logic [NEED_W-1:0]           need;
    logic                        no_space;
    logic                        table_full;
    logic                        more_to_read;

    ffba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = ffba_pkg::entry_t'(ram_rdata_raw);

    // data address of the entry that just came out of the table
    assign entry_addr = cfg.heap_base + ram_rdata.offset
                      + ffba_pkg::DATA_W'(HEADER_BYTES);
    assign new_addr   = cfg.heap_base + used_reg + ffba_pkg::DATA_W'(HEADER_BYTES);

    always_comb
    begin
        hit = 1'b0;
        if (pend_reg)
        begin
            if (req_reg.req_type == ffba_pkg::REQ_FREE)
            begin
                hit = (entry_addr == req_reg.free_addr);
            end
            else
            begin
                hit = !ram_rdata.in_use && (ram_rdata.size >= req_reg.alloc_size);
            end
        end
    end

    assign last         = pend_reg && ((CNT_W'(pend_idx_reg) + CNT_W'(1)) == count_reg);
    assign more_to_read = rd_idx_reg < count_reg;

    assign need = NEED_W'(used_reg) + NEED_W'(req_reg.alloc_size)
                + NEED_W'(HEADER_BYTES);
    assign no_space   = (CMP_W'(need) > CMP_W'(limit_reg))
                      || (need[NEED_W-1:ffba_pkg::DATA_W] != 2'b00);
    assign table_full = (count_reg == CNT_W'(MAX_BLOCKS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ffba_pkg::ST_SCAN;
                end
            end
            ffba_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ffba_pkg::ST_RESP;
                end
                else if ((count_reg == '0) || last)
                begin
                    state_next = ffba_pkg::ST_DECIDE;
                end
            end
            ffba_pkg::ST_DECIDE:
            begin
                state_next = ffba_pkg::ST_RESP;
            end
            ffba_pkg::ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ffba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffba_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        req_next      = req_reg;
        res_next      = res_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        count_next    = count_reg;
        used_next     = used_reg;
        ram_we        = 1'b0;
        ram_waddr     = pend_idx_reg;
        ram_wdata     = ram_rdata;
        case (state_reg)
            ffba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next    = in_data;
                    rd_idx_next = '0;
                end
            end
            ffba_pkg::ST_SCAN:
            begin
                // reads are pipelined: entry i is checked while i+1 is fetched
                if (more_to_read && !hit)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    ram_we           = 1'b1;
                    ram_wdata.in_use = (req_reg.req_type == ffba_pkg::REQ_ALLOC);
                    res_next.status  = ffba_pkg::STAT_OK;
                    if (req_reg.req_type == ffba_pkg::REQ_FREE)
                    begin
                        res_next.data_addr = '0;
                    end
                    else
                    begin
                        res_next.data_addr = entry_addr;
                    end
                end
            end
            ffba_pkg::ST_DECIDE:
            begin
                res_next.data_addr = '0;
                if (req_reg.req_type == ffba_pkg::REQ_FREE)
                begin
                    res_next.status = ffba_pkg::STAT_NOT_FOUND;
                end
                else if (table_full)
                begin
                    res_next.status = ffba_pkg::STAT_TABLE_FULL;
                end
                else if (no_space)
                begin
                    res_next.status = ffba_pkg::STAT_NO_SPACE;
                end
                else
                begin
                    // append a new block at the bump offset
                    ram_we             = 1'b1;
                    ram_waddr          = count_reg[IDX_W-1:0];
                    ram_wdata.size     = req_reg.alloc_size;
                    ram_wdata.offset   = used_reg;
                    ram_wdata.in_use   = 1'b1;
                    count_next         = count_reg + CNT_W'(1);
                    used_next          = need[ffba_pkg::DATA_W-1:0];
                    res_next.status    = ffba_pkg::STAT_OK;
                    res_next.data_addr = new_addr;
                end
            end
            ffba_pkg::ST_RESP:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign res_data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ffba_pkg::ST_IDLE;
            pend_reg   <= 1'b0;
            count_reg  <= '0;
            used_reg   <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            used_reg   <= used_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        pend_idx_reg <= pend_idx_next;
        limit_reg    <= LIM_W'(cfg.heap_pages) * LIM_W'(PAGE_BYTES);
    end

endmodule

@@ hdl/first_fit_block_allocator.sv @@
// channel   | signals                        | transfer
// ----------+--------------------------------+---------------------------
// request   | in_valid, in_ready, in_data    | valid and ready high
// result    | out_valid, out_ready, out_data | valid and ready high
// config    | cfg_we, cfg_index, cfg_data    | write when cfg_we high
//
// one request at a time: a request scans entries 0 to block_count - 1, at most
// MAX_BLOCKS entries, and a hit on entry i ends the scan there; the scan reads
// one entry a cycle through the single read port
// a result waits in the output register while the next request is taken
// reset clears control and counters; the table needs no clearing pass
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ffba_pkg::req_t              in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ffba_pkg::rsp_t              out_data,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ffba_pkg::DATA_W-1:0] cfg_data
);

    ffba_pkg::cfg_t cfg_reg;
    logic           out_valid_reg, out_valid_next;
    ffba_pkg::rsp_t out_data_reg;
    logic           res_valid;
    logic           res_ready;
    ffba_pkg::rsp_t res_data;

    ffba_core #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ffba_pkg::REG_HEAP_BASE:
                    begin
                        cfg_reg.heap_base <= cfg_data;
                    end
                    ffba_pkg::REG_HEAP_PAGES:
                    begin
                        cfg_reg.heap_pages <= cfg_data[ffba_pkg::PAGES_W-1:0];
                    end
                    default:
                    begin
                        cfg_reg <= cfg_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/ffba_checker.sv @@
module ffba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input ffba_pkg::rsp_t out_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in flight");

    // a result never appears right after a request transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early after request");

    // any error answer carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ffba_pkg::STAT_OK) |-> out_data.data_addr == '0)
        else $error("error result with nonzero address");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
